/* rtl/core/tcce_pkg.sv */
// Shared types and constants of the text console cursor engine.
// Payload structs, configuration view, job codes and the CGA palette.
// No dependencies.
`default_nettype none

package tcce_pkg;

    // Configuration port geometry and register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_INK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_PAPER  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEXED_MODE   = 3'd4;

    // Register reset values
    localparam logic [6:0]  RST_GRID_COLUMNS  = 7'd80;
    localparam logic [4:0]  RST_GRID_ROWS     = 5'd25;
    localparam logic [23:0] RST_DEFAULT_INK   = 24'hC0C0C0;
    localparam logic [23:0] RST_DEFAULT_PAPER = 24'h6FA08E;

    // Input operations
    localparam logic [2:0] OP_PUT_CHAR      = 3'd0;
    localparam logic [2:0] OP_SET_ATTR      = 3'd1;
    localparam logic [2:0] OP_SET_CURSOR    = 3'd2;
    localparam logic [2:0] OP_ERASE_LINE    = 3'd3;
    localparam logic [2:0] OP_ERASE_DISPLAY = 3'd4;
    localparam logic [2:0] OP_READ_CURSOR   = 3'd5;

    // Control characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_LINE_FEED = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;

    // Attribute that restores the default colors
    localparam logic [7:0] ATTR_DEFAULT = 8'h07;

    // Erase modes (the unused code is folded onto ERASE_TO_END)
    localparam logic [1:0] ERASE_TO_END    = 2'd0;
    localparam logic [1:0] ERASE_TO_CURSOR = 2'd1;
    localparam logic [1:0] ERASE_ALL       = 2'd2;

    // Result commands
    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_FILL   = 2'd2;
    localparam logic [1:0] CMD_REPORT = 2'd3;

    // 16-entry CGA palette, 0x00RRGGBB
    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    // Depth of the job queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [7:0] target_row;
        logic [7:0] target_col;
        logic [1:0] erase_mode;
    } in_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  cell_row;
        logic [6:0]  col_first;
        logic [6:0]  col_last;
        logic [7:0]  glyph_code;
        logic [23:0] ink;
        logic [23:0] paper;
        logic        last;
    } out_t;

    // Effective grid and color settings seen by front and back end
    typedef struct packed {
        logic [6:0]  cols;
        logic [6:0]  cols_m1;
        logic [4:0]  rows;
        logic [4:0]  rows_m1;
        logic [23:0] default_ink;
        logic [23:0] default_paper;
        logic        indexed_mode;
    } cfg_t;

    typedef enum logic [3:0] {
        J_NONE,
        J_NEWLINE,
        J_RETURN,
        J_TAB,
        J_BACKSPACE,
        J_GLYPH,
        J_ATTR,
        J_CURSOR,
        J_ERASE_LINE,
        J_ERASE_DISPLAY,
        J_REPORT
    } job_kind_t;

    // One classified word in the job queue
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  glyph;
        logic [23:0] ink;
        logic [23:0] paper;
        logic [4:0]  row;
        logic [6:0]  col;
        logic [1:0]  mode;
    } job_t;

endpackage

`default_nettype wire

/* rtl/core/tcce_cfg.sv */
// Configuration registers of the text console cursor engine.
// Holds the five registers and derives the effective grid size.
// Depends on tcce_pkg.
`default_nettype none

module tcce_cfg #(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tcce_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output tcce_pkg::cfg_t                   cfg
);
    import tcce_pkg::*;

    localparam logic [7:0] MaxCols = 8'(MAX_COLS);
    localparam logic [5:0] MaxRows = 6'(MAX_ROWS);

    logic [6:0]  grid_columns_reg;
    logic [4:0]  grid_rows_reg;
    logic [23:0] default_ink_reg;
    logic [23:0] default_paper_reg;
    logic        indexed_mode_reg;
    logic [6:0]  eff_cols;
    logic [4:0]  eff_rows;

    // Write one register per enabled cycle; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_columns_reg  <= RST_GRID_COLUMNS;
            grid_rows_reg     <= RST_GRID_ROWS;
            default_ink_reg   <= RST_DEFAULT_INK;
            default_paper_reg <= RST_DEFAULT_PAPER;
            indexed_mode_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_GRID_COLUMNS:  grid_columns_reg  <= cfg_wr_data[6:0];
                CFG_GRID_ROWS:     grid_rows_reg     <= cfg_wr_data[4:0];
                CFG_DEFAULT_INK:   default_ink_reg   <= cfg_wr_data;
                CFG_DEFAULT_PAPER: default_paper_reg <= cfg_wr_data;
                CFG_INDEXED_MODE:  indexed_mode_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the grid: zero acts as one, oversize acts as the maximum
    always_comb begin
        if (grid_columns_reg == 7'd0) begin
            eff_cols = 7'd1;
        end else if ({1'b0, grid_columns_reg} > MaxCols) begin
            eff_cols = MaxCols[6:0];
        end else begin
            eff_cols = grid_columns_reg;
        end
        if (grid_rows_reg == 5'd0) begin
            eff_rows = 5'd1;
        end else if ({1'b0, grid_rows_reg} > MaxRows) begin
            eff_rows = MaxRows[4:0];
        end else begin
            eff_rows = grid_rows_reg;
        end
    end

    assign cfg.cols          = eff_cols;
    assign cfg.cols_m1       = eff_cols - 7'd1;
    assign cfg.rows          = eff_rows;
    assign cfg.rows_m1       = eff_rows - 5'd1;
    assign cfg.default_ink   = default_ink_reg;
    assign cfg.default_paper = default_paper_reg;
    assign cfg.indexed_mode  = indexed_mode_reg;

endmodule

`default_nettype wire

/* rtl/core/tcce_front.sv */
// Front end of the text console cursor engine.
// Accepts input words, classifies them into jobs and resolves colors and clamps.
// Depends on tcce_pkg.
`default_nettype none

module tcce_front (
    input  logic           s_valid,
    output logic           s_ready,
    input  tcce_pkg::in_t  s_data,
    input  tcce_pkg::cfg_t cfg,
    input  logic           q_full,
    output logic           push,
    output tcce_pkg::job_t push_job
);
    import tcce_pkg::*;

    logic      use_default;
    job_kind_t job_kind;

    // Classify the operation and the control characters
    always_comb begin
        job_kind = J_NONE;
        unique case (s_data.operation)
            OP_PUT_CHAR: begin
                unique case (s_data.char_code)
                    CH_LINE_FEED: job_kind = J_NEWLINE;
                    CH_RETURN:    job_kind = J_RETURN;
                    CH_TAB:       job_kind = J_TAB;
                    CH_BACKSPACE: job_kind = J_BACKSPACE;
                    default:      job_kind = J_GLYPH;
                endcase
            end
            OP_SET_ATTR:      job_kind = J_ATTR;
            OP_SET_CURSOR:    job_kind = J_CURSOR;
            OP_ERASE_LINE:    job_kind = J_ERASE_LINE;
            OP_ERASE_DISPLAY: job_kind = J_ERASE_DISPLAY;
            OP_READ_CURSOR:   job_kind = J_REPORT;
            default:          job_kind = J_NONE;
        endcase
    end

    assign push_job.kind = job_kind;

    // Resolve the attribute through the palette or fall back to the defaults
    assign use_default    = (s_data.attribute == ATTR_DEFAULT) || cfg.indexed_mode;
    assign push_job.ink   = use_default ? cfg.default_ink : PALETTE[s_data.attribute[3:0]];
    assign push_job.paper = use_default ? cfg.default_paper
                                        : PALETTE[{1'b0, s_data.attribute[6:4]}];

    // Clamp the requested cursor to the grid
    assign push_job.row = ({3'b000, cfg.rows} <= s_data.target_row) ? cfg.rows_m1
                                                                     : s_data.target_row[4:0];
    assign push_job.col = ({1'b0, cfg.cols} <= s_data.target_col) ? cfg.cols_m1
                                                                   : s_data.target_col[6:0];

    // Fold the unused erase mode onto erase-to-end
    assign push_job.mode  = (s_data.erase_mode == ERASE_TO_CURSOR ||
                             s_data.erase_mode == ERASE_ALL) ? s_data.erase_mode : ERASE_TO_END;
    assign push_job.glyph = s_data.char_code;

    // Accept while the queue has room; drop operations that do nothing
    assign s_ready = !q_full;
    assign push    = s_valid && s_ready && (job_kind != J_NONE);

endmodule

`default_nettype wire

/* rtl/core/tcce_queue.sv */
// Job queue between front and back end of the text console cursor engine.
// Small register FIFO of classified jobs.
// Depends on tcce_pkg.
`default_nettype none

module tcce_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tcce_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output tcce_pkg::job_t q_job
);
    import tcce_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [PtrW:0]   CountFull = (PtrW + 1)'(QUEUE_DEPTH);

    job_t            entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   count_reg, count_next;

    // Advance pointers with wrap and track the fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign full    = (count_reg == CountFull);
    assign q_valid = (count_reg != '0);
    assign q_job   = entry_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != CountFull || pop))
        else $error("job queue pushed while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("job queue popped while empty");

endmodule

`default_nettype wire

/* rtl/core/tcce_back.sv */
// Back end of the text console cursor engine.
// Keeps cursor and colors, runs each job and drives the registered result port.
// Depends on tcce_pkg.
`default_nettype none

module tcce_back #(
    parameter int TAB_STOP = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  tcce_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  tcce_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output tcce_pkg::out_t m_data
);
    import tcce_pkg::*;

    // Next tab stop: reciprocal multiply, exact for 7-bit columns and stops up to 16
    localparam int TabShift = 12;
    localparam int TabRecip = ((1 << TabShift) + TAB_STOP - 1) / TAB_STOP;
    localparam int ProdW    = 7 + TabShift + 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCROLL = 3'b010,
        S_FILL   = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  cur_col_reg, cur_col_next;
    logic [4:0]  cur_row_reg, cur_row_next;
    logic [23:0] cur_ink_reg, cur_ink_next;
    logic [23:0] cur_paper_reg, cur_paper_next;
    logic [4:0]  fill_row_reg, fill_row_next;
    logic [4:0]  fill_end_reg, fill_end_next;
    logic [1:0]  fill_mode_reg, fill_mode_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    logic             out_free;
    logic [5:0]       row_inc;
    logic             nl_scroll;
    logic [4:0]       nl_row;
    logic [7:0]       col_inc;
    logic             wrap;
    logic             in_grid;
    logic             row_in_grid;
    logic [ProdW-1:0] tab_prod;
    logic [7:0]       tab_q;
    logic [11:0]      tab_next;
    logic             tab_wrap;
    logic             fill_on_cur;
    logic [6:0]       fill_c0, fill_c1;
    out_t             draw_word, scroll_word, report_word, fill_word;

    assign out_free = !m_valid_reg || m_ready;

    // Newline: next row, or stay on the bottom row and scroll
    assign row_inc   = {1'b0, cur_row_reg} + 6'd1;
    assign nl_scroll = (row_inc >= {1'b0, cfg.rows});
    assign nl_row    = nl_scroll ? cfg.rows_m1 : row_inc[4:0];

    // Printable character: draw when inside the grid, advance, wrap at the edge
    assign col_inc     = {1'b0, cur_col_reg} + 8'd1;
    assign wrap        = (col_inc >= {1'b0, cfg.cols});
    assign row_in_grid = (cur_row_reg < cfg.rows);
    assign in_grid     = (cur_col_reg < cfg.cols) && row_in_grid;

    // Tab: (col / TAB_STOP + 1) * TAB_STOP
    assign tab_prod = ProdW'(cur_col_reg) * ProdW'(TabRecip);
    assign tab_q    = tab_prod[ProdW-1:TabShift];
    assign tab_next = (12'(tab_q) + 12'd1) * 12'(TAB_STOP);
    assign tab_wrap = (tab_next >= {5'b00000, cfg.cols});

    // Fill span for the current row of an erase pass
    assign fill_on_cur = (fill_row_reg == cur_row_reg);
    assign fill_c0 = (fill_mode_reg == ERASE_TO_END && fill_on_cur) ? cur_col_reg : 7'd0;
    assign fill_c1 = (fill_mode_reg == ERASE_TO_CURSOR && fill_on_cur &&
                      cur_col_reg < cfg.cols_m1) ? cur_col_reg : cfg.cols_m1;

    // Result words
    always_comb begin
        draw_word            = '0;
        draw_word.command    = CMD_DRAW;
        draw_word.cell_row   = cur_row_reg;
        draw_word.col_first  = cur_col_reg;
        draw_word.glyph_code = q_job.glyph;
        draw_word.ink        = cur_ink_reg;
        draw_word.paper      = cur_paper_reg;
        draw_word.last       = !(wrap && nl_scroll);

        scroll_word          = '0;
        scroll_word.command  = CMD_SCROLL;
        scroll_word.cell_row = cfg.rows_m1;
        scroll_word.col_last = cfg.cols_m1;
        scroll_word.paper    = cfg.default_paper;
        scroll_word.last     = 1'b1;

        report_word           = '0;
        report_word.command   = CMD_REPORT;
        report_word.cell_row  = cur_row_reg;
        report_word.col_first = cur_col_reg;
        report_word.last      = 1'b1;

        fill_word           = '0;
        fill_word.command   = CMD_FILL;
        fill_word.cell_row  = fill_row_reg;
        fill_word.col_first = fill_c0;
        fill_word.col_last  = fill_c1;
        fill_word.paper     = cur_paper_reg;
        fill_word.last      = (fill_row_reg == fill_end_reg);
    end

    // Sequencer: take one job when the result register is free, then finish it
    always_comb begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        cur_ink_next   = cur_ink_reg;
        cur_paper_next = cur_paper_reg;
        fill_row_next  = fill_row_reg;
        fill_end_next  = fill_end_reg;
        fill_mode_next = fill_mode_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    unique case (q_job.kind)
                        J_NEWLINE: begin
                            cur_col_next = 7'd0;
                            cur_row_next = nl_row;
                            if (nl_scroll) begin
                                m_valid_next = 1'b1;
                                m_data_next  = scroll_word;
                            end
                        end
                        J_RETURN: begin
                            cur_col_next = 7'd0;
                        end
                        J_TAB: begin
                            if (tab_wrap) begin
                                cur_col_next = 7'd0;
                                cur_row_next = nl_row;
                                if (nl_scroll) begin
                                    m_valid_next = 1'b1;
                                    m_data_next  = scroll_word;
                                end
                            end else begin
                                cur_col_next = tab_next[6:0];
                            end
                        end
                        J_BACKSPACE: begin
                            if (cur_col_reg != 7'd0) begin
                                cur_col_next = cur_col_reg - 7'd1;
                            end
                        end
                        J_GLYPH: begin
                            if (in_grid) begin
                                m_valid_next = 1'b1;
                                m_data_next  = draw_word;
                            end
                            if (wrap) begin
                                cur_col_next = 7'd0;
                                cur_row_next = nl_row;
                                if (nl_scroll) begin
                                    if (in_grid) begin
                                        state_next = S_SCROLL;
                                    end else begin
                                        m_valid_next = 1'b1;
                                        m_data_next  = scroll_word;
                                    end
                                end
                            end else begin
                                cur_col_next = col_inc[6:0];
                            end
                        end
                        J_ATTR: begin
                            cur_ink_next   = q_job.ink;
                            cur_paper_next = q_job.paper;
                        end
                        J_CURSOR: begin
                            cur_col_next = q_job.col;
                            cur_row_next = q_job.row;
                        end
                        J_ERASE_LINE: begin
                            fill_mode_next = q_job.mode;
                            fill_row_next  = cur_row_reg;
                            fill_end_next  = cur_row_reg;
                            if (row_in_grid) begin
                                state_next = S_FILL;
                            end
                        end
                        J_ERASE_DISPLAY: begin
                            fill_mode_next = q_job.mode;
                            if (q_job.mode == ERASE_ALL) begin
                                fill_row_next = 5'd0;
                                fill_end_next = cfg.rows_m1;
                                state_next    = S_FILL;
                            end else if (q_job.mode == ERASE_TO_CURSOR) begin
                                fill_row_next = 5'd0;
                                fill_end_next = row_in_grid ? cur_row_reg : cfg.rows_m1;
                                state_next    = S_FILL;
                            end else begin
                                fill_row_next = cur_row_reg;
                                fill_end_next = cfg.rows_m1;
                                if (row_in_grid) begin
                                    state_next = S_FILL;
                                end
                            end
                        end
                        J_REPORT: begin
                            m_valid_next = 1'b1;
                            m_data_next  = report_word;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCROLL: begin
                // Emit the scroll that follows a wrapping glyph
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = scroll_word;
                    state_next   = S_IDLE;
                end
            end
            S_FILL: begin
                // One row per cycle while the result register is free; drop an empty span
                if (out_free) begin
                    if (fill_c0 <= fill_c1) begin
                        m_valid_next = 1'b1;
                        m_data_next  = fill_word;
                    end
                    if (fill_row_reg == fill_end_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        fill_row_next = fill_row_reg + 5'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_col_reg   <= 7'd0;
            cur_row_reg   <= 5'd0;
            cur_ink_reg   <= RST_DEFAULT_INK;
            cur_paper_reg <= RST_DEFAULT_PAPER;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            cur_ink_reg   <= cur_ink_next;
            cur_paper_reg <= cur_paper_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Hold erase-pass bookkeeping and the result payload
    always_ff @(posedge aclk) begin
        fill_row_reg  <= fill_row_next;
        fill_end_reg  <= fill_end_next;
        fill_mode_reg <= fill_mode_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_scroll_after_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCROLL |-> m_valid_reg && m_data_reg.command == CMD_DRAW &&
                                  !m_data_reg.last)
        else $error("pending scroll without its draw word in the result register");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FILL |-> fill_row_reg <= fill_end_reg &&
                                fill_end_reg <= cfg.rows_m1)
        else $error("erase pass row outside its range");

    a_fill_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.command == CMD_FILL |->
            m_data_reg.col_first <= m_data_reg.col_last)
        else $error("fill word with an empty span");

endmodule

`default_nettype wire

/* rtl/core/text_console_cursor_engine_unit.sv */
// Top level of the text console cursor engine.
// Ties configuration registers, front end, job queue and back end together.
// Depends on tcce_pkg, tcce_cfg, tcce_front, tcce_queue and tcce_back.
`default_nettype none

// Text console cursor engine. Console commands enter on the s_ channel and are
// classified by the front end into a two-word job queue, so input keeps flowing
// until the queue is full while the back end is busy or the result port is
// stalled. The back end owns the cursor and colors and takes one job per cycle
// whenever it is idle and its result register is free. A printable character
// that wraps on the bottom row gives a draw and then a scroll; an erase takes
// its job, then visits each affected row in turn (up to the number of grid
// rows). Set attribute, set cursor and unused operation codes give no result,
// and unused codes are dropped on entry. Each input's final result carries
// last. Write configuration only while the block is idle; reset restores the
// grid to 80 by 25 and the default colors.
module text_console_cursor_engine_unit #(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tcce_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tcce_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tcce_pkg::out_t                   m_data
);
    import tcce_pkg::*;

    cfg_t cfg;
    logic push, q_full, q_pop, q_valid;
    job_t push_job, q_job;

    tcce_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    tcce_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    tcce_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    tcce_back #(
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

/* tb/tb_text_console_cursor_engine_unit.sv */
// Self-checking testbench for the text console cursor engine top level.
// Drives console words, predicts the cell commands and compares every result word.
// Depends on tcce_pkg and text_console_cursor_engine_unit.
`timescale 1ns / 100ps

module tb_text_console_cursor_engine_unit;

    import tcce_pkg::*;

    localparam int MAX_COLS     = 80;
    localparam int MAX_ROWS     = 25;
    localparam int TAB_STOP     = 8;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    // Operation codes the block drops on entry
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    // Erase mode that behaves like erase to end
    localparam logic [1:0] ERASE_SPARE = 2'd3;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_t                    s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_t                   m_data;

    text_console_cursor_engine_unit #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS),
        .TAB_STOP(TAB_STOP)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // Console state mirror and its copy of the registers
    logic [6:0]  grid_cols_reg = RST_GRID_COLUMNS;
    logic [4:0]  grid_rows_reg = RST_GRID_ROWS;
    logic [23:0] def_ink_reg   = RST_DEFAULT_INK;
    logic [23:0] def_paper_reg = RST_DEFAULT_PAPER;
    logic        indexed_reg   = 1'b0;
    int          cur_col = 0;
    int          cur_row = 0;
    logic [23:0] cur_ink   = RST_DEFAULT_INK;
    logic [23:0] cur_paper = RST_DEFAULT_PAPER;

    in_t  console_words[$];
    out_t fresh_cells[$];
    out_t expected_cells[$];
    logic word_in_flight = 1'b0;
    bit   allow_gaps = 1'b1;
    int   s_gap = 0;
    int   m_gap = 0;
    int   mismatch_count = 0;
    int   stall_cycles = 0;

    function automatic int grid_w();
        if (grid_cols_reg == 0) return 1;
        return (grid_cols_reg > MAX_COLS) ? MAX_COLS : int'(grid_cols_reg);
    endfunction

    function automatic int grid_h();
        if (grid_rows_reg == 0) return 1;
        return (grid_rows_reg > MAX_ROWS) ? MAX_ROWS : int'(grid_rows_reg);
    endfunction

    function automatic void push_cell(logic [1:0] cmd, int row, int c0, int c1,
                                      logic [7:0] glyph, logic [23:0] ink,
                                      logic [23:0] paper);
        out_t w;
        w.command    = cmd;
        w.cell_row   = 5'(row);
        w.col_first  = 7'(c0);
        w.col_last   = 7'(c1);
        w.glyph_code = glyph;
        w.ink        = ink;
        w.paper      = paper;
        w.last       = 1'b0;
        fresh_cells.push_back(w);
    endfunction

    // Fill a span in the current paper; skip rows off the grid and empty spans
    function automatic void fill_cells(int row, int c0, int c1);
        int cols;
        cols = grid_w();
        if (row >= grid_h()) return;
        if (c1 >= cols) c1 = cols - 1;
        if (c0 > c1) return;
        push_cell(CMD_FILL, row, c0, c1, 8'h00, 24'h0, cur_paper);
    endfunction

    // Return to column 0 and step down, scrolling on the bottom row
    function automatic void line_feed();
        int rows;
        rows = grid_h();
        cur_col = 0;
        if (cur_row + 1 >= rows) begin
            push_cell(CMD_SCROLL, rows - 1, 0, grid_w() - 1, 8'h00, 24'h0, def_paper_reg);
            cur_row = rows - 1;
        end else begin
            cur_row++;
        end
    endfunction

    // Work out the cell commands of one accepted word and queue them
    function automatic void compute_cell_cmds(in_t w);
        int   cols;
        int   rows;
        int   nxt;
        out_t tail;
        cols = grid_w();
        rows = grid_h();
        fresh_cells.delete();
        case (w.operation)
            OP_PUT_CHAR: begin
                case (w.char_code)
                    CH_LINE_FEED: line_feed();
                    CH_RETURN:    cur_col = 0;
                    CH_TAB: begin
                        nxt = (cur_col / TAB_STOP + 1) * TAB_STOP;
                        if (nxt >= cols) line_feed();
                        else cur_col = nxt;
                    end
                    CH_BACKSPACE: begin
                        if (cur_col > 0) cur_col--;
                    end
                    default: begin
                        if (cur_col < cols && cur_row < rows)
                            push_cell(CMD_DRAW, cur_row, cur_col, 0, w.char_code,
                                      cur_ink, cur_paper);
                        cur_col++;
                        if (cur_col >= cols) line_feed();
                    end
                endcase
            end
            OP_SET_ATTR: begin
                if (w.attribute == ATTR_DEFAULT || indexed_reg) begin
                    cur_ink   = def_ink_reg;
                    cur_paper = def_paper_reg;
                end else begin
                    cur_ink   = PALETTE[w.attribute[3:0]];
                    cur_paper = PALETTE[{1'b0, w.attribute[6:4]}];
                end
            end
            OP_SET_CURSOR: begin
                cur_col = (w.target_col >= cols) ? cols - 1 : int'(w.target_col);
                cur_row = (w.target_row >= rows) ? rows - 1 : int'(w.target_row);
            end
            OP_ERASE_LINE: begin
                case (w.erase_mode)
                    ERASE_TO_CURSOR: fill_cells(cur_row, 0, cur_col);
                    ERASE_ALL:       fill_cells(cur_row, 0, cols - 1);
                    default:         fill_cells(cur_row, cur_col, cols - 1);
                endcase
            end
            OP_ERASE_DISPLAY: begin
                case (w.erase_mode)
                    ERASE_ALL: begin
                        for (int r = 0; r < rows; r++) fill_cells(r, 0, cols - 1);
                    end
                    ERASE_TO_CURSOR: begin
                        for (int r = 0; r < cur_row && r < rows; r++)
                            fill_cells(r, 0, cols - 1);
                        fill_cells(cur_row, 0, cur_col);
                    end
                    default: begin
                        fill_cells(cur_row, cur_col, cols - 1);
                        for (int r = cur_row + 1; r < rows; r++) fill_cells(r, 0, cols - 1);
                    end
                endcase
            end
            OP_READ_CURSOR: push_cell(CMD_REPORT, cur_row, cur_col, 0, 8'h00, 24'h0, 24'h0);
            default: ;
        endcase
        cur_col &= 'h7F;
        cur_row &= 'h1F;
        // Mark the final word of this input
        if (fresh_cells.size() > 0) begin
            tail = fresh_cells.pop_back();
            tail.last = 1'b1;
            fresh_cells.push_back(tail);
        end
        foreach (fresh_cells[i]) expected_cells.push_back(fresh_cells[i]);
    endfunction

    function automatic string show_cell(out_t w);
        return $sformatf("cmd=%0d row=%0d c0=%0d c1=%0d glyph=%02h ink=%06h paper=%06h last=%0b",
                         w.command, w.cell_row, w.col_first, w.col_last, w.glyph_code,
                         w.ink, w.paper, w.last);
    endfunction

    function automatic bit cells_match(out_t a, out_t b);
        return a.command === b.command && a.cell_row === b.cell_row &&
               a.col_first === b.col_first && a.col_last === b.col_last &&
               a.glyph_code === b.glyph_code && a.ink === b.ink &&
               a.paper === b.paper && a.last === b.last;
    endfunction

    function automatic in_t make_word(logic [2:0] op, logic [7:0] ch, logic [7:0] attr,
                                      logic [7:0] row, logic [7:0] col, logic [1:0] mode);
        in_t w;
        w.operation  = op;
        w.char_code  = ch;
        w.attribute  = attr;
        w.target_row = row;
        w.target_col = col;
        w.erase_mode = mode;
        return w;
    endfunction

    // Random console word, mostly text with a spread of control commands
    function automatic in_t random_word();
        in_t w;
        int  pick;
        int  sub;
        w.char_code  = 8'($urandom);
        w.attribute  = 8'($urandom);
        w.target_row = 8'($urandom);
        w.target_col = 8'($urandom);
        w.erase_mode = 2'($urandom);
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 11);
        if (pick < 55) begin
            w.operation = OP_PUT_CHAR;
            case (sub)
                0: w.char_code = CH_LINE_FEED;
                1: w.char_code = CH_RETURN;
                2: w.char_code = CH_TAB;
                3: w.char_code = CH_BACKSPACE;
                default: ;
            endcase
        end else if (pick < 63) begin
            w.operation = OP_SET_ATTR;
            if (sub < 3) w.attribute = ATTR_DEFAULT;
        end else if (pick < 73) begin
            w.operation = OP_SET_CURSOR;
            if (sub < 8) begin
                w.target_row = 8'($urandom_range(0, grid_h() - 1));
                w.target_col = 8'($urandom_range(0, grid_w() - 1));
            end
        end else if (pick < 81) begin
            w.operation = OP_ERASE_LINE;
        end else if (pick < 86) begin
            w.operation = OP_ERASE_DISPLAY;
        end else if (pick < 96) begin
            w.operation = OP_READ_CURSOR;
        end else begin
            w.operation = (sub < 6) ? OP_SPARE_6 : OP_SPARE_7;
        end
        return w;
    endfunction

    task automatic queue_random(int count);
        in_t w;
        int  n;
        n = 0;
        while (n < count) begin
            w = random_word();
            console_words.push_back(w);
            if (w.operation <= OP_READ_CURSOR) n++;
        end
    endtask

    // Wait until every word is taken and every result has come, then let the block settle
    task automatic drain();
        while (console_words.size() != 0 || word_in_flight || expected_cells.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
    endtask

    // Program all five registers on an idle block and mirror them
    task automatic load_settings(int cols, int rows, logic [23:0] ink, logic [23:0] paper,
                                 logic indexed);
        write_reg(CFG_GRID_COLUMNS, CFG_DATA_W'(cols));
        write_reg(CFG_GRID_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_DEFAULT_INK, ink);
        write_reg(CFG_DEFAULT_PAPER, paper);
        write_reg(CFG_INDEXED_MODE, CFG_DATA_W'(indexed));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        grid_cols_reg = 7'(cols);
        grid_rows_reg = 5'(rows);
        def_ink_reg   = ink;
        def_paper_reg = paper;
        indexed_reg   = indexed;
    endtask

    // Input driver: hold a word until taken, otherwise idle in bursts or send the next
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!word_in_flight) begin
            if (s_gap > 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (console_words.size() != 0 && allow_gaps &&
                         $urandom_range(0, 7) == 0) begin
                s_gap = $urandom_range(1, 12) - 1;
                s_valid <= 1'b0;
            end else if (console_words.size() != 0) begin
                s_data <= console_words.pop_front();
                s_valid <= 1'b1;
                word_in_flight = 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Predict at the edge that takes the word
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            compute_cell_cmds(s_data);
            word_in_flight = 1'b0;
        end
    end

    // Result side back-pressure in random bursts
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap--;
            m_ready <= 1'b0;
        end else if (allow_gaps && $urandom_range(0, 7) == 0) begin
            m_gap = $urandom_range(1, 12) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cells.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result word: %s", show_cell(m_data));
            end else begin
                want = expected_cells.pop_front();
                if (!cells_match(want, m_data)) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected %s\n          actual   %s",
                                 show_cell(want), show_cell(m_data));
                end
            end
        end
    end

    // Stop a hung run: count cycles in which no word moves
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL text_console_cursor_engine_unit");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words on the reset grid
        console_words.push_back(make_word(OP_READ_CURSOR, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_PUT_CHAR, 8'h41, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_PUT_CHAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3));
        console_words.push_back(make_word(OP_PUT_CHAR, CH_TAB, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_PUT_CHAR, CH_BACKSPACE, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_PUT_CHAR, CH_RETURN, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_PUT_CHAR, CH_LINE_FEED, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_SET_ATTR, 8'h00, 8'hFF, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_PUT_CHAR, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_SET_ATTR, 8'h00, ATTR_DEFAULT, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_SET_CURSOR, 8'h00, 8'h00, 8'hFF, 8'hFF, 2'd0));
        console_words.push_back(make_word(OP_PUT_CHAR, 8'h5A, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_SET_CURSOR, 8'h00, 8'h00, 8'd24, 8'd75, 2'd0));
        console_words.push_back(make_word(OP_PUT_CHAR, CH_TAB, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_SET_CURSOR, 8'h00, 8'h00, 8'd10, 8'd40, 2'd0));
        console_words.push_back(make_word(OP_ERASE_LINE, 8'h00, 8'h00, 8'h00, 8'h00,
                                          ERASE_TO_END));
        console_words.push_back(make_word(OP_ERASE_LINE, 8'h00, 8'h00, 8'h00, 8'h00,
                                          ERASE_TO_CURSOR));
        console_words.push_back(make_word(OP_ERASE_LINE, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_ALL));
        console_words.push_back(make_word(OP_ERASE_LINE, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_SPARE));
        console_words.push_back(make_word(OP_ERASE_DISPLAY, 8'h00, 8'h00, 8'h00, 8'h00,
                                          ERASE_TO_END));
        console_words.push_back(make_word(OP_ERASE_DISPLAY, 8'h00, 8'h00, 8'h00, 8'h00,
                                          ERASE_TO_CURSOR));
        console_words.push_back(make_word(OP_ERASE_DISPLAY, 8'h00, 8'h00, 8'h00, 8'h00,
                                          ERASE_ALL));
        console_words.push_back(make_word(OP_SET_CURSOR, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_PUT_CHAR, CH_BACKSPACE, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_SPARE_6, 8'h41, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_SPARE_7, 8'h41, 8'h00, 8'h00, 8'h00, 2'd0));
        console_words.push_back(make_word(OP_READ_CURSOR, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0));
        drain();

        // Full grid with fresh default colors
        load_settings(80, 25, 24'($urandom), 24'($urandom), 1'b0);
        queue_random(90);
        drain();

        // Smallest grid, indexed mode
        load_settings(1, 1, 24'hFFFFFF, 24'h000000, 1'b1);
        queue_random(60);
        drain();

        // Oversized register values clamp to the maximum grid
        load_settings(127, 31, 24'($urandom), 24'($urandom), 1'b0);
        queue_random(80);
        drain();

        // Shrink the grid under the cursor
        load_settings($urandom_range(2, 20), $urandom_range(2, 8), 24'($urandom),
                      24'($urandom), 1'b0);
        queue_random(80);
        drain();

        // Zero-sized grid acts as one cell
        load_settings(0, 0, 24'($urandom), 24'($urandom), 1'b1);
        queue_random(30);
        drain();

        // Back to the full grid at full rate
        allow_gaps = 1'b0;
        load_settings(80, 25, 24'($urandom), 24'($urandom), 1'b0);
        queue_random(120);
        drain();

        if (mismatch_count == 0)
            $display("PASS text_console_cursor_engine_unit");
        else
            $display("FAIL text_console_cursor_engine_unit");
        $finish;
    end

endmodule
